/* rtl/core/dccm_pkg.sv */
// Package for the duty-cycle capture meter: constants, phase codes and digit helpers.
package dccm_pkg;

    localparam int DCCM_COUNTER_BITS = 16;
    localparam int CAPTURE_BITS      = 16;
    localparam int DUTY_BITS         = 7;
    localparam int SEG_BITS          = 7;
    localparam int DUTY_SCALE        = 100;
    localparam int DUTY_MAX          = 99;

    localparam logic [1:0] PH_WAIT_START = 2'd0;
    localparam logic [1:0] PH_WAIT_FALL  = 2'd1;
    localparam logic [1:0] PH_WAIT_RISE  = 2'd2;

    // Common-cathode pattern of one decimal digit, bit 0 is segment a.
    function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_BITS-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Tens digit of a value below one hundred, found by comparing against multiples of ten.
    function automatic logic [3:0] tens_digit(input logic [DUTY_BITS-1:0] value);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (value >= DUTY_BITS'(k * 10)) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/core/duty_cycle_capture_meter_unit.sv */
// Duty-cycle capture meter: edge phase tracking, shared-subtractor divider and digit output.
//
// Usage: each transfer on the slave stream (i_s_axis_*) carries one capture time,
// the timer value at a PWM edge counted from the last period start. The first
// edge after reset starts a period, the next edge gives the high time and the
// edge after that gives the period; from then on edges alternate between high
// time and period. Every input transfer yields exactly one master-stream
// transfer (o_m_axis_*) with the current duty in percent and the seven-segment
// patterns of its two digits; tuser flags a freshly computed duty.
// An edge that needs no division registers its result, which appears in the
// cycle after the transfer. A period end with high time below the period runs
// a restoring divide through one shared subtractor, one quotient bit per cycle
// for seven bits, then loads the output register from a done state. The same
// subtractor compares high time against the period at acceptance, so a duty
// of one hundred percent or more saturates to 99 without dividing.
// Edges needing no division pass at one item per cycle unless the output stalls;
// none enters while dividing. A stalled receiver holds the output register, and
// the slave side stops accepting until that register can take the next result.
// Reset (synchronous, active low) returns to waiting for the first rising edge,
// clears the stored high time and duty and empties the output register.
module duty_cycle_capture_meter_unit #(
    parameter int COUNTER_BITS = dccm_pkg::DCCM_COUNTER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] capture_time
    input  logic [dccm_pkg::CAPTURE_BITS-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [6:0] duty_percent, [13:7] tens_segments, [20:14] units_segments, [23:21] zero
    output logic [23:0]                       o_m_axis_tdata,
    // [0] updated
    output logic                              o_m_axis_tuser
);
    import dccm_pkg::*;

    localparam int TW = (COUNTER_BITS < CAPTURE_BITS) ? COUNTER_BITS : CAPTURE_BITS;
    localparam int QW = DUTY_BITS;
    localparam int DW = TW + QW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [1:0]      r_phase;
    logic [TW-1:0]   r_high;
    logic [QW-1:0]   r_duty;
    logic [TW-1:0]   r_div;
    logic [TW-1:0]   r_rem;
    logic [QW-1:0]   r_low;
    logic [2:0]      r_cnt;
    logic            r_out_valid;
    logic [23:0]     r_out_data;
    logic            r_out_user;

    logic [TW-1:0]   w_time;
    logic [DW-1:0]   w_prod;
    logic [TW:0]     w_sub_a;
    logic [TW:0]     w_sub_b;
    logic [TW+1:0]   w_sub;
    logic            w_borrow;
    logic [TW:0]     w_trial;
    logic            w_accept;
    logic            w_out_free;
    logic            w_period;
    logic            w_start_div;
    logic            w_load_now;
    logic            w_load_done;
    logic [QW-1:0]   n_duty;
    logic            n_updated;
    logic [3:0]      w_tens;
    logic [3:0]      w_units;

    assign w_time     = i_s_axis_tdata[TW-1:0];
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    assign w_prod = DW'(r_high) * DW'(DUTY_SCALE);

    // The one subtractor: high time against period at acceptance, trial remainder while dividing.
    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_sub_a = (r_state == S_IDLE) ? {1'b0, r_high} : w_trial;
    assign w_sub_b = (r_state == S_IDLE) ? {1'b0, w_time} : {1'b0, r_div};
    assign w_sub   = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_borrow = w_sub[TW+1];

    assign w_period    = (r_phase == PH_WAIT_RISE) && (w_time != '0);
    assign w_start_div = w_accept && w_period && w_borrow;
    assign w_load_now  = w_accept && !w_start_div;
    assign w_load_done = (r_state == S_DONE) && w_out_free;

    always_comb begin
        n_duty    = r_duty;
        n_updated = 1'b0;
        if (r_state == S_DONE) begin
            n_updated = 1'b1;
        end else if (w_period) begin
            n_duty    = QW'(DUTY_MAX);
            n_updated = 1'b1;
        end
    end

    assign w_tens  = tens_digit(n_duty);
    assign w_units = 4'(n_duty - QW'(w_tens) * QW'(10));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_WAIT_START;
            r_high      <= '0;
            r_duty      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_now || w_load_done) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {3'b000, seg_pattern(w_units), seg_pattern(w_tens), n_duty};
                r_out_user  <= n_updated;
                r_duty      <= n_duty;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_phase == PH_WAIT_FALL) begin
                            r_high  <= w_time;
                            r_phase <= PH_WAIT_RISE;
                        end else begin
                            r_phase <= PH_WAIT_FALL;
                        end
                        if (w_start_div) begin
                            // High time below the period keeps the quotient under 128.
                            r_rem   <= w_prod[DW-1:QW];
                            r_low   <= w_prod[QW-1:0];
                            r_div   <= w_time;
                            r_cnt   <= 3'(QW - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_borrow ? w_trial[TW-1:0] : w_sub[TW-1:0];
                    r_low <= {r_low[QW-2:0], !w_borrow};
                    if (r_cnt == 3'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 3'd1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The quotient lands in the duty register as the divide finishes.
            if (r_state == S_DIV && r_cnt == 3'd0) begin
                r_duty <= {r_low[QW-2:0], !w_borrow};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below the period");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[6:0] <= 7'(DUTY_MAX)))
        else $error("duty out of range");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_div |=> (r_state == S_DIV && r_phase == PH_WAIT_FALL))
        else $error("divide did not start after a period end");

    a_done_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_done |=> (o_m_axis_tvalid && o_m_axis_tuser))
        else $error("divide result not flagged as updated");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("input accepted while dividing");

endmodule
